### rtl/core/pesd_pkg.sv
package pesd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] HEX_BAD    = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_escape;
    } t_out_word;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] high_part;
    } t_state;

    typedef struct packed {
        logic      emit;
        t_out_word word;
    } t_result;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
        end else begin
            v = HEX_BAD;
        end
        return v;
    endfunction

endpackage

### rtl/core/pesd_step.sv
module pesd_step import pesd_pkg::*; (
    input  t_state   i_state,
    input  t_in_word i_word,
    output t_state   o_state,
    output t_result  o_result
);

    logic [7:0] digit;

    assign digit = hex_value(i_word.in_byte);

    // next state
    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            PH_HIGH: begin
                // invalid digit gives 0xf0 since its low nibble is all ones
                o_state.high_part = {digit[3:0], 4'h0};
                o_state.phase     = i_word.in_last ? PH_IDLE : PH_LOW;
            end
            PH_LOW: begin
                o_state.phase = PH_IDLE;
            end
            default: begin
                if (i_word.in_byte == CH_PERCENT && !i_word.in_last) begin
                    o_state.phase = PH_HIGH;
                end else begin
                    o_state.phase = PH_IDLE;
                end
            end
        endcase
    end

    // result
    always_comb begin
        o_result.emit            = 1'b1;
        o_result.word.out_byte   = i_word.in_byte;
        o_result.word.out_last   = i_word.in_last;
        o_result.word.bad_escape = 1'b0;
        case (i_state.phase)
            PH_HIGH: begin
                o_result.emit            = i_word.in_last;
                o_result.word.out_byte   = 8'h00;
                o_result.word.bad_escape = i_word.in_last;
            end
            PH_LOW: begin
                o_result.word.out_byte = i_state.high_part | digit;
            end
            default: begin
                if (i_word.in_byte == CH_PERCENT) begin
                    o_result.emit            = i_word.in_last;
                    o_result.word.out_byte   = 8'h00;
                    o_result.word.bad_escape = i_word.in_last;
                end else if (i_word.in_byte == CH_PLUS) begin
                    o_result.word.out_byte = CH_SPACE;
                end
            end
        endcase
    end

endmodule

### rtl/core/percent_escape_stream_decoder_unit.sv
// channel   direction  valid          stall          word
// in        input      i_in_valid     o_in_stall     i_in_word  (in_byte, in_last)
// out       output     o_out_valid    i_out_stall    o_out_word (out_byte, out_last, bad_escape)
//
// one word per cycle sustained while the output is not stalled
// the input register feeds one decode step, whose result lands in the output register
// the percent sign and the high digit produce no output word unless they end the string
// synchronous active-low reset empties both registers and closes any open escape
// an output stall holds a full output register and, once the input register is full, the input
module percent_escape_stream_decoder_unit import pesd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    t_state    r_state;
    t_state    n_state;
    t_result   step_result;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      out_ready;
    logic      advance;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    pesd_step u_step (
        .i_state  (r_state),
        .i_word   (r_in_word),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.phase     <= PH_IDLE;
            r_state.high_part <= 8'h00;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (out_ready) begin
                r_out_valid <= advance && step_result.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance && step_result.emit) begin
            r_out_word <= step_result.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.bad_escape |->
            r_out_word.out_last && r_out_word.out_byte == 8'h00)
        else $error("bad escape word not final or not zero");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

    a_low_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_state.phase == PH_LOW |=> r_out_valid && !r_out_word.bad_escape)
        else $error("low digit produced no word");

endmodule
